// ----- hdl/bli_pkg.sv -----
// ----------------------------------------------------------------------------
// bli_pkg
// Shared constants and types for the breakpoint linear interpolator.
// ----------------------------------------------------------------------------
package bli_pkg;

  localparam int POINTS   = 64;
  localparam int ADDR_W   = $clog2(POINTS);
  localparam int PTR_W    = ADDR_W + 1;
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 16;
  localparam int DIV_STEPS = DATA_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] FACTOR_MAX = {DATA_W{1'b1}};

  localparam logic [1:0] CFG_POINT_COUNT    = 2'd0;
  localparam logic [1:0] CFG_TABLE_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_FACTOR = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

endpackage

// ----- hdl/breakpoint_linear_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// breakpoint_linear_interpolator_core
// Stores breakpoints in one synchronous table and answers queries by walking
// it for the enclosing segment and interpolating with a serial divider.
// A query that uses the default factor answers in the cycle after start;
// a query that walks the table reads one entry per cycle, then takes a
// multiply step and the serial divide. One item is in work at a time.
// Reset clears the registers to point_count 0, table_enable 0 and
// default_factor 16384; the breakpoint table is not cleared.
// ----------------------------------------------------------------------------
module breakpoint_linear_interpolator_core
  import bli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [ADDR_W-1:0]        in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_x,
  input  logic [DATA_W-1:0]        in_entry_factor,
  input  logic signed [DATA_W-1:0] in_query_eta,
  output logic                     out_strobe,
  output logic [DATA_W-1:0]        out_factor,
  output logic                     out_in_range,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  logic [2*DATA_W-1:0] mem [POINTS];
  logic [2*DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] point_count_r;
  logic               table_enable_r;
  logic [DATA_W-1:0]  default_factor_r;

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  n_r, n_nxt;
  logic              first_r, first_nxt;
  logic signed [DATA_W-1:0] q_r, q_nxt;
  logic signed [DATA_W-1:0] prev_x_r, prev_x_nxt;
  logic [DATA_W-1:0] prev_y_r, prev_y_nxt;
  logic [DATA_W-1:0] dy_r, dy_nxt;
  logic              dy_neg_r, dy_neg_nxt;
  logic [DATA_W-1:0] dq_r, dq_nxt;
  logic [DATA_W-1:0] dx_r, dx_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  logic [DATA_W-1:0] out_factor_r, out_factor_nxt;
  logic              out_in_range_r, out_in_range_nxt;

  logic                     accept;
  logic [PTR_W-1:0]         n_clamp;
  logic signed [DATA_W-1:0] cur_x;
  logic [DATA_W-1:0]        cur_y;
  logic signed [DATA_W:0]   dx_full;
  logic signed [DATA_W:0]   dq_full;
  logic [2*DATA_W-1:0]      prod;
  logic [DATA_W:0]          shifted;
  logic                     fits;
  logic signed [DATA_W+1:0] sum;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign rd_addr = ptr_r[ADDR_W-1:0];
  assign n_clamp = (point_count_r > COUNT_W'(POINTS)) ? PTR_W'(POINTS)
                                                      : PTR_W'(point_count_r);
  assign cur_x   = $signed(rd_data_r[2*DATA_W-1:DATA_W]);
  assign cur_y   = rd_data_r[DATA_W-1:0];
  assign dx_full = (DATA_W+1)'(cur_x) - (DATA_W+1)'(prev_x_r);
  assign dq_full = (DATA_W+1)'(q_r) - (DATA_W+1)'(prev_x_r);
  assign prod    = dy_r * dq_r;
  assign shifted = {rem_r, lo_r[DATA_W-1]};
  assign fits    = (shifted >= {1'b0, dx_r});
  assign sum     = dy_neg_r ? ($signed({2'b00, prev_y_r}) - $signed({2'b00, lo_r}))
                            : ($signed({2'b00, prev_y_r}) + $signed({2'b00, lo_r}));

  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_WRITE)) begin
      mem[in_entry_index] <= {in_entry_x, in_entry_factor};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r    <= '0;
      table_enable_r   <= 1'b0;
      default_factor_r <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT:    point_count_r    <= cfg_wdata[COUNT_W-1:0];
        CFG_TABLE_ENABLE:   table_enable_r   <= cfg_wdata[0];
        CFG_DEFAULT_FACTOR: default_factor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt        = state_r;
    ptr_nxt          = ptr_r;
    n_nxt            = n_r;
    first_nxt        = first_r;
    q_nxt            = q_r;
    prev_x_nxt       = prev_x_r;
    prev_y_nxt       = prev_y_r;
    dy_nxt           = dy_r;
    dy_neg_nxt       = dy_neg_r;
    dq_nxt           = dq_r;
    dx_nxt           = dx_r;
    rem_nxt          = rem_r;
    lo_nxt           = lo_r;
    dcnt_nxt         = dcnt_r;
    out_strobe_nxt   = 1'b0;
    out_factor_nxt   = out_factor_r;
    out_in_range_nxt = out_in_range_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_action == ACT_QUERY)) begin
          q_nxt   = in_query_eta;
          n_nxt   = n_clamp;
          ptr_nxt = '0;
          if (!table_enable_r || (n_clamp < PTR_W'(2))) begin
            out_strobe_nxt   = 1'b1;
            out_factor_nxt   = default_factor_r;
            out_in_range_nxt = 1'b0;
          end else begin
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        ptr_nxt   = ptr_r + PTR_W'(1);
        first_nxt = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (first_r) begin
          first_nxt  = 1'b0;
          prev_x_nxt = cur_x;
          prev_y_nxt = cur_y;
          ptr_nxt    = ptr_r + PTR_W'(1);
        end else if ((prev_x_r <= q_r) && (q_r < cur_x)) begin
          dx_nxt     = dx_full[DATA_W-1:0];
          dq_nxt     = dq_full[DATA_W-1:0];
          dy_neg_nxt = (cur_y < prev_y_r);
          dy_nxt     = (cur_y < prev_y_r) ? (prev_y_r - cur_y) : (cur_y - prev_y_r);
          state_nxt  = S_MUL;
        end else if (ptr_r == n_r) begin
          out_strobe_nxt = 1'b1;
          if (q_r == cur_x) begin
            out_factor_nxt   = cur_y;
            out_in_range_nxt = 1'b1;
          end else begin
            out_factor_nxt   = default_factor_r;
            out_in_range_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end else begin
          prev_x_nxt = cur_x;
          prev_y_nxt = cur_y;
          ptr_nxt    = ptr_r + PTR_W'(1);
        end
      end
      S_MUL: begin
        rem_nxt   = prod[2*DATA_W-1:DATA_W];
        lo_nxt    = prod[DATA_W-1:0];
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = fits ? DATA_W'(shifted - {1'b0, dx_r}) : shifted[DATA_W-1:0];
        lo_nxt   = {lo_r[DATA_W-2:0], fits};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_strobe_nxt   = 1'b1;
        out_in_range_nxt = 1'b1;
        if (sum < 0) begin
          out_factor_nxt = '0;
        end else if (sum > $signed({2'b00, FACTOR_MAX})) begin
          out_factor_nxt = FACTOR_MAX;
        end else begin
          out_factor_nxt = sum[DATA_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      first_r      <= 1'b0;
      ptr_r        <= '0;
      dcnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      first_r      <= first_nxt;
      ptr_r        <= ptr_nxt;
      dcnt_r       <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    q_r            <= q_nxt;
    prev_x_r       <= prev_x_nxt;
    prev_y_r       <= prev_y_nxt;
    dy_r           <= dy_nxt;
    dy_neg_r       <= dy_neg_nxt;
    dq_r           <= dq_nxt;
    dx_r           <= dx_nxt;
    rem_r          <= rem_nxt;
    lo_r           <= lo_nxt;
    out_factor_r   <= out_factor_nxt;
    out_in_range_r <= out_in_range_nxt;
  end

  assign out_strobe   = out_strobe_r;
  assign out_factor   = out_factor_r;
  assign out_in_range = out_in_range_r;

endmodule
